FILE: hdl/dssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssp_pkg
// shared types and constants of the depth-sorted sphere projection block
// ----------------------------------------------------------------------------
package dssp_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_SINE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_COSINE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT   = 2'd3;

  localparam int KEY_W = 17;
  localparam logic signed [KEY_W-1:0] KEY_MIN = -17'sd65536;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 17'sd65535;

  // quotient width used by the serial divider
  localparam int DIV_N_W = 34;
  localparam int DIV_D_W = 19;
  localparam int DIV_STEPS = 17;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pos_t;

  typedef struct packed {
    logic [14:0] radius;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } radcol_t;

  typedef struct packed {
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
    logic [14:0]        offset;
    logic [14:0]        near;
  } view_cfg_t;

  // divider request to the shared unit
  typedef struct packed {
    logic                       start;
    logic signed [DIV_N_W-1:0] num;
    logic signed [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic signed [DIV_N_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: hdl/dssp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssp_divider
// signed restoring divider, truncates toward zero, two quotient bits a cycle
// ----------------------------------------------------------------------------
module dssp_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  dssp_pkg::div_req_t  req,
  output dssp_pkg::div_rsp_t  rsp
);
  import dssp_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [DIV_N_W-1:0] quo_r, quo_nxt;
  logic [DIV_N_W-1:0] rem_r, rem_nxt;
  logic [DIV_D_W-1:0] den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  logic [DIV_N_W-1:0] num_abs;
  logic [DIV_D_W-1:0] den_abs;
  logic [DIV_N_W-1:0] r1, r2, q1, q2;
  logic [DIV_N_W:0]   t1, t2;

  assign num_abs = req.num[DIV_N_W-1] ? DIV_N_W'(-req.num) : DIV_N_W'(req.num);
  assign den_abs = req.den[DIV_D_W-1] ? DIV_D_W'(-req.den) : DIV_D_W'(req.den);

  always_comb begin
    t1 = {rem_r, quo_r[DIV_N_W-1]} - {{(DIV_N_W-DIV_D_W+1){1'b0}}, den_r};
    if (!t1[DIV_N_W]) begin
      r1 = t1[DIV_N_W-1:0];
    end else begin
      r1 = {rem_r[DIV_N_W-2:0], quo_r[DIV_N_W-1]};
    end
    q1 = {quo_r[DIV_N_W-2:0], ~t1[DIV_N_W]};
    t2 = {r1, q1[DIV_N_W-1]} - {{(DIV_N_W-DIV_D_W+1){1'b0}}, den_r};
    if (!t2[DIV_N_W]) begin
      r2 = t2[DIV_N_W-1:0];
    end else begin
      r2 = {r1[DIV_N_W-2:0], q1[DIV_N_W-1]};
    end
    q2 = {q1[DIV_N_W-2:0], ~t2[DIV_N_W]};
  end

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = num_abs;
      rem_nxt  = '0;
      den_nxt  = den_abs;
      neg_nxt  = req.num[DIV_N_W-1] ^ req.den[DIV_D_W-1];
      cnt_nxt  = CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = q2;
      rem_nxt = r2;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? DIV_N_W'(-quo_r) : quo_r;

endmodule

FILE: hdl/dssp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssp_core
// sphere stores, depth keys, selection sort by repeated scans and projection
// ----------------------------------------------------------------------------
module dssp_core #(
  parameter int MAX_SPHERES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dssp_pkg::view_cfg_t   cfg,
  input  logic                  start,
  output logic                  busy,
  input  dssp_pkg::pos_t        in_pos,
  input  dssp_pkg::radcol_t     in_rc,
  input  logic                  in_last,
  output dssp_pkg::div_req_t    div_req,
  input  dssp_pkg::div_rsp_t    div_rsp,
  output logic                  out_strobe,
  output logic signed [15:0]    out_screen_x,
  output logic signed [15:0]    out_screen_y,
  output logic signed [16:0]    out_screen_depth,
  output logic [14:0]           out_screen_radius,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_visible,
  output logic                  out_last_result
);
  import dssp_pkg::*;

  localparam int AW = $clog2(MAX_SPHERES);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_KEY_RD, S_KEY_MUL, S_KEY_WR, S_SCAN_RD, S_SCAN,
    S_FETCH, S_MUL, S_DIV_GO, S_DIV_X, S_DIV_Y, S_DIV_R, S_EMIT
  } state_t;

  // memories
  pos_t                pos_mem [MAX_SPHERES];
  radcol_t             rc_mem  [MAX_SPHERES];
  logic signed [KEY_W-1:0] key_mem [MAX_SPHERES];

  state_t              state_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       idx_r;      // key pass / scan address
  logic [CW-1:0]       emitted_r;
  logic [AW-1:0]       best_r;
  logic signed [KEY_W-1:0] best_key_r;
  logic                best_ok_r;
  logic [AW-1:0]       prev_idx_r;
  logic signed [KEY_W-1:0] prev_key_r;
  logic                prev_ok_r;
  logic [CW-1:0]       scan_idx_r; // index of data in key_q

  pos_t                pos_q;
  radcol_t             rc_q;
  logic signed [KEY_W-1:0] key_q;

  logic signed [32:0]  prod_a_r, prod_b_r;
  logic signed [33:0]  sum_r;
  logic signed [KEY_W-1:0] depth_r;
  logic                vis_r;
  logic signed [15:0]  sx_r, sy_r;
  logic [14:0]         sr_r;
  logic [AW-1:0]       rd_addr;
  logic                pos_we, key_we;
  logic [AW-1:0]       wr_addr;
  logic signed [KEY_W-1:0] key_wr;

  logic signed [33:0]  key_sum;
  logic signed [19:0]  key_floor;
  logic signed [KEY_W-1:0] key_sat;
  logic signed [KEY_W+1:0] dep_sum;
  logic signed [KEY_W-1:0] dep_sat;
  logic signed [DIV_D_W-1:0] den4;

  assign busy = (state_r != S_LOAD);

  // store writes
  assign pos_we  = start && (state_r == S_LOAD) && (count_r < CW'(MAX_SPHERES));
  assign wr_addr = AW'(count_r);

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= in_pos;
      rc_mem[wr_addr]  <= in_rc;
    end
    if (key_we) begin
      key_mem[AW'(idx_r)] <= key_wr;
    end
    pos_q <= pos_mem[rd_addr];
    rc_q  <= rc_mem[rd_addr];
    key_q <= key_mem[rd_addr];
  end

  // the chosen sphere stays on the read port until its result is sent
  always_comb begin
    rd_addr = AW'(idx_r);
    if (state_r inside {S_FETCH, S_MUL, S_DIV_GO, S_DIV_X, S_DIV_Y, S_DIV_R, S_EMIT}) begin
      rd_addr = best_r;
    end
  end

  // key arithmetic
  assign key_sum   = 34'(prod_a_r) + 34'(prod_b_r);
  assign key_floor = 20'(key_sum >>> 14);
  always_comb begin
    if (key_floor > 20'(KEY_MAX)) begin
      key_sat = KEY_MAX;
    end else if (key_floor < 20'(KEY_MIN)) begin
      key_sat = KEY_MIN;
    end else begin
      key_sat = KEY_W'(key_floor);
    end
  end
  assign key_we = (state_r == S_KEY_WR);
  assign key_wr = key_sat;

  assign dep_sum = (KEY_W+2)'(key_q) + (KEY_W+2)'($signed({1'b0, cfg.offset}));
  always_comb begin
    if (dep_sum > (KEY_W+2)'(KEY_MAX)) begin
      dep_sat = KEY_MAX;
    end else if (dep_sum < (KEY_W+2)'(KEY_MIN)) begin
      dep_sat = KEY_MIN;
    end else begin
      dep_sat = KEY_W'(dep_sum);
    end
  end
  assign den4 = DIV_D_W'({depth_r, 2'b00});

  function automatic logic signed [15:0] sat16(input logic signed [DIV_N_W-1:0] v);
    if (v > 34'sd32767) begin
      return 16'sd32767;
    end else if (v < -34'sd32768) begin
      return -16'sd32768;
    end
    return 16'(v);
  endfunction

  function automatic logic signed [DIV_N_W-1:0] zquot(input logic signed [DIV_N_W-1:0] n);
    // zero depth: saturate toward the numerator sign
    if (n > 0) begin
      return 34'sd65535;
    end else if (n < 0) begin
      return -34'sd65536;
    end
    return '0;
  endfunction

  logic signed [DIV_N_W-1:0] num_x, num_y, num_r, qsel;

  assign num_x = 34'(prod_a_r) - 34'(prod_b_r);
  assign num_y = DIV_N_W'($signed({pos_q.y, 14'd0}));
  assign num_r = DIV_N_W'($signed({1'b0, rc_q.radius, 14'd0}));

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = num_x;
    div_req.den   = den4;
    if (state_r == S_DIV_GO && vis_r) begin
      div_req.start = 1'b1;
    end else if (state_r == S_DIV_X && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.num   = num_y;
    end else if (state_r == S_DIV_Y && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.num   = num_r;
    end
  end

  always_comb begin
    qsel = div_rsp.quo;
    if (depth_r == '0) begin
      case (state_r)
        S_DIV_X: qsel = zquot(num_x);
        S_DIV_Y: qsel = zquot(num_y);
        default: qsel = zquot(num_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      out_strobe  <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_EMIT);
      case (state_r)
        S_LOAD: begin
          if (start) begin
            if (pos_we) begin
              count_r <= count_r + 1'b1;
            end
            if (in_last) begin
              idx_r <= '0;
              state_r <= S_KEY_RD;
            end
          end
        end
        S_KEY_RD: begin
          // count is at least one here unless the store was empty
          if (idx_r == count_r) begin
            idx_r       <= '0;
            emitted_r   <= '0;
            prev_ok_r   <= 1'b0;
            best_ok_r   <= 1'b0;
            state_r     <= (count_r == '0) ? S_LOAD : S_SCAN_RD;
          end else begin
            state_r <= S_KEY_MUL;
          end
        end
        S_KEY_MUL: begin
          prod_a_r <= 33'(pos_q.x) * 33'(cfg.cosine);
          prod_b_r <= 33'(pos_q.z) * 33'(cfg.sine);
          state_r  <= S_KEY_WR;
        end
        S_KEY_WR: begin
          idx_r   <= idx_r + 1'b1;
          state_r <= S_KEY_RD;
        end
        S_SCAN_RD: begin
          scan_idx_r <= idx_r;
          idx_r      <= idx_r + 1'b1;
          state_r    <= S_SCAN;
        end
        S_SCAN: begin
          // only entries after the previous pick in far-first, load order
          // qualify; strict greater keeps load order among equal keys
          if ((!prev_ok_r || key_q < prev_key_r ||
               (key_q == prev_key_r && AW'(scan_idx_r) > prev_idx_r)) &&
              (!best_ok_r || key_q > best_key_r)) begin
            best_r     <= AW'(scan_idx_r);
            best_key_r <= key_q;
            best_ok_r  <= 1'b1;
          end
          if (idx_r == count_r) begin
            state_r <= S_FETCH;
          end else begin
            scan_idx_r <= idx_r;
            idx_r      <= idx_r + 1'b1;
          end
        end
        S_FETCH: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          depth_r  <= dep_sat;
          vis_r    <= ($signed({dep_sat[KEY_W-1], dep_sat}) >= $signed({3'b000, cfg.near}));
          prod_a_r <= 33'(pos_q.x) * 33'(cfg.sine);
          prod_b_r <= 33'(pos_q.z) * 33'(cfg.cosine);
          sx_r <= '0;
          sy_r <= '0;
          sr_r <= '0;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= vis_r ? S_DIV_X : S_EMIT;
        end
        S_DIV_X: begin
          if (div_rsp.done) begin
            sx_r    <= sat16(qsel);
            state_r <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_rsp.done) begin
            sy_r    <= sat16(qsel);
            state_r <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_rsp.done) begin
            if (qsel > 34'sd32767) begin
              sr_r <= 15'h7fff;
            end else if (qsel < 0) begin
              sr_r <= '0;
            end else begin
              sr_r <= 15'(qsel);
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_screen_x      <= sx_r;
          out_screen_y      <= sy_r;
          out_screen_depth  <= depth_r;
          out_screen_radius <= sr_r;
          out_red           <= rc_q.red;
          out_green         <= rc_q.green;
          out_blue          <= rc_q.blue;
          out_visible       <= vis_r;
          out_last_result   <= (emitted_r + 1'b1 == count_r);
          prev_idx_r <= best_r;
          prev_key_r <= best_key_r;
          prev_ok_r  <= 1'b1;
          emitted_r <= emitted_r + 1'b1;
          best_ok_r <= 1'b0;
          idx_r     <= '0;
          if (emitted_r + 1'b1 == count_r) begin
            count_r <= '0;
            state_r <= S_LOAD;
          end else begin
            state_r <= S_SCAN_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: hdl/depth_sorted_sphere_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_sorted_sphere_projection
// loads spheres, sorts them far to near and projects each one to the screen
// ----------------------------------------------------------------------------
// usage:
//   input transaction: start high while busy is low. each one stores a sphere
//   while the store has room. one with in_last_sphere set begins the frame:
//   busy rises and stays up until the last result has been sent.
//   per frame: a key pass over the spheres (store read, multiply, key write
//   for each), then per result a scan over the key memory (one read port),
//   fetch and setup, three quotients on the shared serial divider for a
//   visible sphere (none for a culled one) and an emit step.
//   results: out_strobe marks one transaction a cycle; the receiver cannot
//   stall, out_last_result marks the end of the frame.
//   configuration writes go in at any time the block is idle.
//   reset clears the sphere count and the registers to their defaults;
//   stores are not cleared.
// ----------------------------------------------------------------------------
module depth_sorted_sphere_projection #(
  parameter int MAX_SPHERES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [15:0]                  in_pos_x,
  input  logic signed [15:0]                  in_pos_y,
  input  logic signed [15:0]                  in_pos_z,
  input  logic [14:0]                         in_radius,
  input  logic [7:0]                          in_red,
  input  logic [7:0]                          in_green,
  input  logic [7:0]                          in_blue,
  input  logic                                in_last_sphere,
  input  logic                                cfg_we,
  input  logic [dssp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dssp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_strobe,
  output logic signed [15:0]                  out_screen_x,
  output logic signed [15:0]                  out_screen_y,
  output logic signed [16:0]                  out_screen_depth,
  output logic [14:0]                         out_screen_radius,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic                                out_visible,
  output logic                                out_last_result
);
  import dssp_pkg::*;

  view_cfg_t cfg_r;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  pos_t      in_pos;
  radcol_t   in_rc;
  logic      core_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sine   <= 16'sd16384;
      cfg_r.cosine <= 16'sd0;
      cfg_r.offset <= 15'd6144;
      cfg_r.near   <= 15'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VIEW_SINE:    cfg_r.sine   <= cfg_data;
        REG_VIEW_COSINE:  cfg_r.cosine <= cfg_data;
        REG_DEPTH_OFFSET: cfg_r.offset <= cfg_data[14:0];
        REG_NEAR_LIMIT:   cfg_r.near   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign in_pos = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
  assign in_rc  = '{radius: in_radius, red: in_red, green: in_green, blue: in_blue};
  assign busy   = core_busy;

  dssp_core #(.MAX_SPHERES(MAX_SPHERES)) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .start             (start),
    .busy              (core_busy),
    .in_pos            (in_pos),
    .in_rc             (in_rc),
    .in_last           (in_last_sphere),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .out_strobe        (out_strobe),
    .out_screen_x      (out_screen_x),
    .out_screen_y      (out_screen_y),
    .out_screen_depth  (out_screen_depth),
    .out_screen_radius (out_screen_radius),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_visible       (out_visible),
    .out_last_result   (out_last_result)
  );

  dssp_divider u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

FILE: hdl/dssp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssp_checker
// port-level checks of the projection block
// ----------------------------------------------------------------------------
module dssp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_sphere,
  input logic out_strobe,
  input logic out_visible,
  input logic out_last_result,
  input logic [14:0] out_screen_radius
);

  // a frame start makes the block busy
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_sphere |=> busy) else $error("frame did not start");

  // results only come while a frame is being worked on
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result outside a frame");

  // the last result ends the frame
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_result |-> !busy) else $error("busy after last result");

  // culled spheres have no radius
  a_cull: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_visible |-> out_screen_radius == 15'd0)
    else $error("culled sphere with radius");

endmodule

bind depth_sorted_sphere_projection dssp_checker u_chk (
  .clk (clk),
  .rst_n (rst_n),
  .start (start),
  .busy (busy),
  .in_last_sphere (in_last_sphere),
  .out_strobe (out_strobe),
  .out_visible (out_visible),
  .out_last_result (out_last_result),
  .out_screen_radius (out_screen_radius)
);
